[sv/cifr_pkg.sv]
package cifr_pkg;

  // Sample and coefficient format.
  localparam int DATA_W   = 16;
  localparam int FRAC_W   = 15;
  localparam int COEF_W   = 2 * DATA_W;
  localparam int MAX_TAPS = 3;

  // Coefficient register file.
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = $clog2(NUM_COEFS);

  localparam logic [COEF_W-1:0] COEF_B0_RESET = 32'h7FFF_0000;

  // Default tap counts for the top level.
  localparam int FEEDFORWARD_TAPS_DEF = 3;
  localparam int FEEDBACK_TAPS_DEF    = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_idx_t;

  // Complex Q1.15 value, packed as the coefficient registers: real on top.
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

endpackage

[sv/cifr_cmul.sv]
module cifr_cmul (
  input  cifr_pkg::cplx_t x,
  input  cifr_pkg::cplx_t c,
  output cifr_pkg::cplx_t p
);

  localparam int PROD_W = 2 * cifr_pkg::DATA_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] rr;
  logic signed [PROD_W-1:0] ii;
  logic signed [PROD_W-1:0] ri;
  logic signed [PROD_W-1:0] ir;
  logic signed [SUM_W-1:0]  re_full;
  logic signed [SUM_W-1:0]  im_full;

  // Four partial products of the complex multiply.
  assign rr = x.re * c.re;
  assign ii = x.im * c.im;
  assign ri = x.re * c.im;
  assign ir = x.im * c.re;

  // Exact real and imaginary sums before scaling.
  assign re_full = SUM_W'(rr) - SUM_W'(ii);
  assign im_full = SUM_W'(ri) + SUM_W'(ir);

  // A floor shift by the fraction width keeps the bits just above it.
  assign p.re = re_full[cifr_pkg::FRAC_W +: cifr_pkg::DATA_W];
  assign p.im = im_full[cifr_pkg::FRAC_W +: cifr_pkg::DATA_W];

endmodule

[sv/complex_iir_filter_unit.sv]
// Path: an accepted request is held in the input stage, then registered as a result in the
// result stage and offered from there; out_stall holds the result stage and, behind it, the input stage.
// Throughput: one request per cycle while out_stall is low; the new output is formed
// combinationally from the previous one, which the output delay line holds in a register.
// Reset (rst, synchronous): empties both stages, clears the delay lines, and restores
// the coefficients (b0 near one, all others zero).
module complex_iir_filter_unit #(
  parameter int FEEDFORWARD_TAPS = cifr_pkg::FEEDFORWARD_TAPS_DEF,
  parameter int FEEDBACK_TAPS    = cifr_pkg::FEEDBACK_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cifr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cifr_pkg::COEF_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cifr_pkg::DATA_W-1:0]    sample_real,
  input  logic signed [cifr_pkg::DATA_W-1:0]    sample_imag,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cifr_pkg::DATA_W-1:0]    out_real,
  output logic signed [cifr_pkg::DATA_W-1:0]    out_imag
);

  logic [cifr_pkg::COEF_W-1:0] coef [cifr_pkg::NUM_COEFS];

  logic            x_valid;
  cifr_pkg::cplx_t x_reg;
  logic            res_valid;
  cifr_pkg::cplx_t res;

  logic            take;
  logic            advance;
  cifr_pkg::cplx_t prod0;
  cifr_pkg::cplx_t ff_sum;
  cifr_pkg::cplx_t fb_sum;
  cifr_pkg::cplx_t y;

  // Coefficient registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[cifr_pkg::REG_B0] <= cifr_pkg::COEF_B0_RESET;
      for (int k = 1; k < cifr_pkg::NUM_COEFS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_we && (cfg_index < cifr_pkg::CFG_IDX_W'(cifr_pkg::NUM_COEFS))) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // Handshake: the input stage moves on when the result stage is empty or drains.
  assign advance  = x_valid && (!res_valid || !out_stall);
  assign in_stall = x_valid && !advance;
  assign take     = in_valid && !in_stall;

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (take) begin
      x_valid <= 1'b1;
    end else if (advance) begin
      x_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_reg.re <= sample_real;
      x_reg.im <= sample_imag;
    end
  end

  // Current sample times b0.
  cifr_cmul u_cmul_b0 (
    .x (x_reg),
    .c (cifr_pkg::cplx_t'(coef[cifr_pkg::REG_B0])),
    .p (prod0)
  );

  // Feedforward delay line and its products.
  generate
    if (FEEDFORWARD_TAPS > 1) begin : g_ff
      localparam int FF_LEN = FEEDFORWARD_TAPS - 1;
      cifr_pkg::cplx_t past_in [FF_LEN];
      cifr_pkg::cplx_t ff_prod [FF_LEN];

      for (genvar k = 0; k < FF_LEN; k++) begin : g_tap
        cifr_cmul u_cmul (
          .x (past_in[k]),
          .c (cifr_pkg::cplx_t'(coef[int'(cifr_pkg::REG_B1) + k])),
          .p (ff_prod[k])
        );
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          for (int k = 0; k < FF_LEN; k++) begin
            past_in[k] <= '0;
          end
        end else if (advance) begin
          past_in[0] <= x_reg;
          for (int k = 1; k < FF_LEN; k++) begin
            past_in[k] <= past_in[k-1];
          end
        end
      end

      always_comb begin
        ff_sum = '0;
        for (int k = 0; k < FF_LEN; k++) begin
          ff_sum.re = ff_sum.re + ff_prod[k].re;
          ff_sum.im = ff_sum.im + ff_prod[k].im;
        end
      end
    end else begin : g_no_ff
      assign ff_sum = '0;
    end
  endgenerate

  // Feedback delay line and its products.
  generate
    if (FEEDBACK_TAPS > 1) begin : g_fb
      localparam int FB_LEN = FEEDBACK_TAPS - 1;
      cifr_pkg::cplx_t past_out [FB_LEN];
      cifr_pkg::cplx_t fb_prod  [FB_LEN];

      for (genvar k = 0; k < FB_LEN; k++) begin : g_tap
        cifr_cmul u_cmul (
          .x (past_out[k]),
          .c (cifr_pkg::cplx_t'(coef[int'(cifr_pkg::REG_A1) + k])),
          .p (fb_prod[k])
        );
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          for (int k = 0; k < FB_LEN; k++) begin
            past_out[k] <= '0;
          end
        end else if (advance) begin
          past_out[0] <= y;
          for (int k = 1; k < FB_LEN; k++) begin
            past_out[k] <= past_out[k-1];
          end
        end
      end

      always_comb begin
        fb_sum = '0;
        for (int k = 0; k < FB_LEN; k++) begin
          fb_sum.re = fb_sum.re + fb_prod[k].re;
          fb_sum.im = fb_sum.im + fb_prod[k].im;
        end
      end
    end else begin : g_no_fb
      assign fb_sum = '0;
    end
  endgenerate

  // Filter output; every sum wraps in 16 bits.
  assign y.re = prod0.re + ff_sum.re - fb_sum.re;
  assign y.im = prod0.im + ff_sum.im - fb_sum.im;

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= y;
    end
  end

  assign out_valid = res_valid;
  assign out_real  = res.re;
  assign out_imag  = res.im;

endmodule

[sv/cifr_checker.sv]
module cifr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [cifr_pkg::DATA_W-1:0] out_real,
  input logic signed [cifr_pkg::DATA_W-1:0] out_imag
);

  logic [1:0] in_flight;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 2'(in_take) - 2'(out_take);
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_real) && $stable(out_imag))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // The two stages never hold more than two requests, and no result appears from nothing.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    (in_flight <= 2'd2) && (!out_valid || (in_flight != 2'd0)))
    else $error("pipeline occupancy out of range");

  // An empty block never stalls its input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (in_flight == 2'd0) |-> !in_stall)
    else $error("input stalled while empty");

endmodule

bind complex_iir_filter_unit cifr_checker u_cifr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_real  (out_real),
  .out_imag  (out_imag)
);
